// File: sv/pwbs_pkg.sv
// Shared types and constants for the per-word byte sorter.
// No dependencies; imported by pwbs_cell, per_word_byte_sorter, pwbs_checker and the testbench.
package pwbs_pkg;

    localparam int BYTE_W = 8;
    localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'd32;

    // Per-cycle command broadcast to every sorting cell.
    typedef struct packed {
        logic insert;   // place the incoming byte into the sorted row
        logic shift;    // move the row one cell toward the output
    } cell_ctrl_t;

endpackage

// File: sv/pwbs_cell.sv
// One cell of the systolic insertion row: holds one byte and its valid bit.
// Depends on pwbs_pkg (cell_ctrl_t, BYTE_W).
module pwbs_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pwbs_pkg::cell_ctrl_t        ctrl,
    input  logic [pwbs_pkg::BYTE_W-1:0] ins_byte,
    input  logic                        prev_le,
    input  logic [pwbs_pkg::BYTE_W-1:0] prev_byte,
    input  logic                        prev_valid,
    input  logic [pwbs_pkg::BYTE_W-1:0] next_byte,
    input  logic                        next_valid,
    output logic                        le,
    output logic [pwbs_pkg::BYTE_W-1:0] cell_byte,
    output logic                        cell_valid
);
    import pwbs_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              valid_reg;
    logic              valid_next;

    // Held byte stays in front of the incoming one.
    assign le = valid_reg && (byte_reg <= ins_byte);

    always_comb
    begin
        byte_next  = byte_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            byte_next  = next_byte;
            valid_next = next_valid;
        end
        else if (ctrl.insert && !le)
        begin
            // Take the new byte at the insertion point, else take the neighbor's.
            if (prev_le)
            begin
                byte_next  = ins_byte;
                valid_next = 1'b1;
            end
            else
            begin
                byte_next  = prev_byte;
                valid_next = prev_valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign cell_byte  = byte_reg;
    assign cell_valid = valid_reg;

endmodule

// File: sv/per_word_byte_sorter.sv
// Top level of the per-word byte sorter: control, output register, cell row.
// Depends on pwbs_pkg and pwbs_cell.
//
// Usage:
//   Bytes of a text line arrive on the s_axis channel, one per transfer, with
//   s_axis_tlast on the final byte of the line. Non-space bytes are placed
//   into a row of MAX_WORD sorting cells as they arrive, so the word is always
//   held in ascending order. A space or the last byte ends the word: the row
//   then shifts out through the m_axis output register, smallest byte first,
//   followed by the space if one ended the word. m_axis_tuser flags every byte
//   of a word that lost bytes beyond MAX_WORD; m_axis_tlast marks the line's
//   final output byte.
// Accepting and draining:
//   Word bytes are taken back to back. Ending a word, with or without a
//   trailing space, drains the row: one shift per kept byte moves it into
//   the output register, and a final step emits the space or just returns
//   to accepting. No input is taken while draining. The ending transfer sets
//   the drain state; the first sorted byte is then loaded into the output register.
// Reset clears the row, the counters and the output register.
// A stalled receiver holds the output register; draining pauses with it, and
// input bytes are still taken while a finished byte waits to be picked up.
module per_word_byte_sorter
#(
    parameter int MAX_WORD = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // in_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // out_last
    output logic [0:0] m_axis_tuser    // [0] word_overflow
);
    import pwbs_pkg::*;

    localparam int CNT_W = $clog2(MAX_WORD + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WORD);

    localparam logic [0:0] ST_ACCEPT = 1'b0;
    localparam logic [0:0] ST_DRAIN  = 1'b1;

    logic [0:0]        state_reg,      state_next;
    logic [CNT_W-1:0]  count_reg,      count_next;
    logic              dropped_reg,    dropped_next;
    logic              word_last_reg,  word_last_next;
    logic              space_pend_reg, space_pend_next;
    logic              space_last_reg, space_last_next;
    logic              out_valid_reg,  out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg,   out_byte_next;
    logic              out_last_reg,   out_last_next;
    logic              out_ovf_reg,    out_ovf_next;

    cell_ctrl_t        ctrl;
    logic              in_xfer;
    logic              load_out;
    logic              is_space;

    logic [BYTE_W-1:0] cell_byte [MAX_WORD];
    logic [MAX_WORD-1:0] cell_valid;
    logic [MAX_WORD-1:0] cell_le;

    assign s_axis_tready = (state_reg == ST_ACCEPT);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign is_space      = (s_axis_tdata == SPACE_BYTE);
    assign load_out      = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        dropped_next    = dropped_reg;
        word_last_next  = word_last_reg;
        space_pend_next = space_pend_reg;
        space_last_next = space_last_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_ovf_next    = out_ovf_reg;
        ctrl.insert     = 1'b0;
        ctrl.shift      = 1'b0;

        case (state_reg)
            ST_ACCEPT:
            begin
                if (in_xfer)
                begin
                    if (is_space)
                    begin
                        // End the word; emit the space after it.
                        space_pend_next = 1'b1;
                        space_last_next = s_axis_tlast;
                        state_next      = ST_DRAIN;
                    end
                    else
                    begin
                        if (count_reg < MAX_CNT)
                        begin
                            ctrl.insert = 1'b1;
                            count_next  = count_reg + 1'b1;
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                        end
                        if (s_axis_tlast)
                        begin
                            word_last_next = 1'b1;
                            state_next     = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (load_out)
                begin
                    if (count_reg != '0)
                    begin
                        // Advance the row; the smallest byte goes out.
                        ctrl.shift     = 1'b1;
                        out_valid_next = 1'b1;
                        out_byte_next  = cell_byte[0];
                        out_last_next  = word_last_reg && (count_reg == CNT_W'(1));
                        out_ovf_next   = dropped_reg;
                        count_next     = count_reg - 1'b1;
                    end
                    else
                    begin
                        if (space_pend_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_byte_next  = SPACE_BYTE;
                            out_last_next  = space_last_reg;
                            out_ovf_next   = 1'b0;
                        end
                        space_pend_next = 1'b0;
                        dropped_next    = 1'b0;
                        word_last_next  = 1'b0;
                        state_next      = ST_ACCEPT;
                    end
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_ACCEPT;
            count_reg      <= '0;
            dropped_reg    <= 1'b0;
            word_last_reg  <= 1'b0;
            space_pend_reg <= 1'b0;
            space_last_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            dropped_reg    <= dropped_next;
            word_last_reg  <= word_last_next;
            space_pend_reg <= space_pend_next;
            space_last_reg <= space_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    // Sorting row: cell 0 holds the smallest byte and faces the output.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_WORD; gi++)
        begin : g_cell
            logic              p_le;
            logic [BYTE_W-1:0] p_byte;
            logic              p_valid;
            logic [BYTE_W-1:0] n_byte;
            logic              n_valid;

            if (gi == 0)
            begin : g_head
                assign p_le    = 1'b1;
                assign p_byte  = '0;
                assign p_valid = 1'b0;
            end
            else
            begin : g_body
                assign p_le    = cell_le[gi-1];
                assign p_byte  = cell_byte[gi-1];
                assign p_valid = cell_valid[gi-1];
            end

            if (gi == MAX_WORD - 1)
            begin : g_tail
                assign n_byte  = '0;
                assign n_valid = 1'b0;
            end
            else
            begin : g_mid
                assign n_byte  = cell_byte[gi+1];
                assign n_valid = cell_valid[gi+1];
            end

            pwbs_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .ins_byte   (s_axis_tdata),
                .prev_le    (p_le),
                .prev_byte  (p_byte),
                .prev_valid (p_valid),
                .next_byte  (n_byte),
                .next_valid (n_valid),
                .le         (cell_le[gi]),
                .cell_byte  (cell_byte[gi]),
                .cell_valid (cell_valid[gi])
            );
        end
    endgenerate

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_byte_reg;
    assign m_axis_tlast    = out_last_reg;
    assign m_axis_tuser[0] = out_ovf_reg;

    // Word length never exceeds the row.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("word length beyond row capacity");

    // Occupied cells match the word length.
    a_row_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("cell row occupancy out of step with word length");

    // A space never carries the overflow flag.
    a_space_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.shift == 1'b0 && state_reg == ST_DRAIN && load_out && space_pend_reg
         && count_reg == '0) |=> (m_axis_tvalid && !m_axis_tuser[0]))
        else $error("space emitted with overflow flag");

endmodule

// File: test/pwbs_checker.sv
`timescale 1ns / 1ps
// Checker for the per-word byte sorter. It predicts the sorted output bytes
// from the input transfers and compares every output transfer with them.
// Depends on pwbs_pkg.
module pwbs_checker
#(
    parameter int MAX_WORD = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic       m_axis_tlast,
    input  logic [0:0] m_axis_tuser,
    output int         bad_bytes,
    output int         bytes_owed
);
    import pwbs_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ovf;
    } sorted_byte_t;

    sorted_byte_t sorted_out_q[$];
    sorted_byte_t oldest;
    sorted_byte_t space_out;
    logic [7:0]   word_buf [MAX_WORD];
    int           word_len;
    bit           word_dropped;

    // Queue the kept bytes of the buffered word in ascending order, then
    // clear the buffer and the overflow mark.
    task automatic flush_sorted_word(input bit mark_last);
        logic [7:0]   row [MAX_WORD];
        logic [7:0]   v;
        int           j;
        sorted_byte_t e;
        for (int i = 0; i < word_len; i++)
        begin
            v = word_buf[i];
            j = i;
            while (j > 0 && row[j-1] > v)
            begin
                row[j] = row[j-1];
                j--;
            end
            row[j] = v;
        end
        for (int i = 0; i < word_len; i++)
        begin
            e.data = row[i];
            e.last = mark_last && (i == word_len - 1);
            e.ovf  = word_dropped;
            sorted_out_q.push_back(e);
        end
        word_len     = 0;
        word_dropped = 0;
    endtask

    initial
    begin
        bad_bytes  = 0;
        bytes_owed = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sorted_out_q.delete();
            word_len     = 0;
            word_dropped = 0;
            bytes_owed   = 0;
        end
        else
        begin
            // Compare the output transfer first: it can only stem from
            // inputs taken at earlier edges.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (sorted_out_q.size() == 0)
                begin
                    $display("%0t: unexpected output: expected none, %s%02h last=%0d ovf=%0d",
                             $time, "got byte=", m_axis_tdata, m_axis_tlast,
                             m_axis_tuser[0]);
                    bad_bytes++;
                end
                else
                begin
                    oldest = sorted_out_q.pop_front();
                    if (oldest.data !== m_axis_tdata || oldest.last !== m_axis_tlast ||
                        oldest.ovf !== m_axis_tuser[0])
                    begin
                        $display({"%0t: output mismatch: expected byte=%02h last=%0d ",
                                  "ovf=%0d, got byte=%02h last=%0d ovf=%0d"},
                                 $time, oldest.data, oldest.last, oldest.ovf,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
                        bad_bytes++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tdata == SPACE_BYTE)
                begin
                    flush_sorted_word(1'b0);
                    space_out.data = SPACE_BYTE;
                    space_out.last = s_axis_tlast;
                    space_out.ovf  = 1'b0;
                    sorted_out_q.push_back(space_out);
                end
                else
                begin
                    if (word_len < MAX_WORD)
                    begin
                        word_buf[word_len] = s_axis_tdata;
                        word_len++;
                    end
                    else
                    begin
                        word_dropped = 1;
                    end
                    if (s_axis_tlast)
                        flush_sorted_word(1'b1);
                end
            end
            bytes_owed = sorted_out_q.size();
        end
    end

endmodule

// File: test/tb_per_word_byte_sorter.sv
`timescale 1ns / 1ps
// Testbench top for the per-word byte sorter: clock, reset, input and output
// stream drivers and the verdict. Depends on pwbs_pkg, pwbs_checker and the
// per_word_byte_sorter RTL.
module tb_per_word_byte_sorter;

    import pwbs_pkg::*;

    localparam int MAX_WORD    = 32;
    localparam int ITEM_TARGET = 230;  // stop the random part here
    localparam int CALM_FROM   = 190;  // no idling past this many items
    localparam int HOLD_AT     = 90;   // start the long receiver hold here
    localparam int HOLD_CYCLES = 80;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [0:0] m_axis_tuser;

    int bad_bytes;
    int bytes_owed;
    int items_sent;
    bit idling_on;
    bit hold_req;

    per_word_byte_sorter #(
        .MAX_WORD(MAX_WORD)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    pwbs_checker #(
        .MAX_WORD(MAX_WORD)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser),
        .bad_bytes    (bad_bytes),
        .bytes_owed   (bytes_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop: far beyond the slowest correct run.
    initial
    begin
        #1000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offer one byte on the input channel and hold it until the transfer.
    // Called and returning at a falling edge; when idling is on, an optional
    // random gap drops tvalid first.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        if (items_sent >= CALM_FROM)
            idling_on = 0;
        if (items_sent == HOLD_AT)
            hold_req = 1;
        @(negedge clk);
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == SPACE_BYTE);
        return b;
    endfunction

    // Send a word of random non-space bytes; mark the final one as the line
    // end when asked.
    task automatic send_word(input int len, input bit ends_line);
        for (int i = 0; i < len; i++)
            send_byte(word_char(), ends_line && (i == len - 1));
    endtask

    // Send a run of spaces; the last space may close the line.
    task automatic send_spaces(input int n, input bit ends_line);
        for (int i = 0; i < n; i++)
            send_byte(SPACE_BYTE, ends_line && (i == n - 1));
    endtask

    // Output side: ready most of the time, random stall bursts while idling is
    // on, and one long hold-off so that the input channel backs up.
    initial
    begin
        int stall_left;
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (hold_req)
            begin
                hold_req      = 0;
                m_axis_tready <= 1'b0;
                stall_left    = HOLD_CYCLES - 1;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left    = $urandom_range(0, 2);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int len;
        int pick;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        items_sent    = 0;
        idling_on     = 1;
        hold_req      = 0;
        rst_n         = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed lines.
        // A space with nothing buffered passes alone.
        send_byte(SPACE_BYTE, 1'b0);
        // Byte extremes, the zero byte among them, end on a space.
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'h21, 1'b0);
        send_byte(8'h1f, 1'b0);
        send_byte(SPACE_BYTE, 1'b0);
        // Run of spaces, the last one closing the line on an empty buffer.
        send_byte(SPACE_BYTE, 1'b0);
        send_byte(SPACE_BYTE, 1'b1);
        // Single-byte line ending on a word byte.
        send_byte(8'h41, 1'b1);
        // Word closed by a last space.
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(SPACE_BYTE, 1'b1);
        // Word ending the line on a non-space byte, with duplicates.
        send_byte(8'h7a, 1'b0);
        send_byte(8'h79, 1'b0);
        send_byte(8'h7a, 1'b0);
        send_byte(8'h78, 1'b1);

        // Random part: lines of words and space runs. Force one overflowing
        // word up front, then mostly short words, some near or past capacity,
        // and a little noise of arbitrary bytes.
        send_word(MAX_WORD + 3, 1'b0);
        send_spaces(1, 1'b0);
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                if (pick <= 6)
                    len = $urandom_range(0, 6);
                else if (pick <= 8)
                    len = $urandom_range(7, MAX_WORD);
                else
                    len = $urandom_range(MAX_WORD - 1, MAX_WORD + 5);
                if (len > 0 && $urandom_range(0, 4) == 0)
                    send_word(len, 1'b1);
                else
                begin
                    send_word(len, 1'b0);
                    send_spaces($urandom_range(1, 3), $urandom_range(0, 5) == 0);
                end
            end
        end
        // Close the last line so the block ends idle.
        send_byte(word_char(), 1'b1);
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every predicted byte, then keep watching for anything
        // stray before the verdict.
        wait (bytes_owed == 0);
        repeat (MAX_WORD + 8) @(posedge clk);
        if (bad_bytes == 0 && bytes_owed == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
sv/pwbs_pkg.sv
sv/pwbs_cell.sv
sv/per_word_byte_sorter.sv
test/pwbs_checker.sv
test/tb_per_word_byte_sorter.sv
